FILE: rtl/fcn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcn_pkg
// Shared types, codes and the one's complement checksum step of the
// full-cone UDP NAT table.
// ----------------------------------------------------------------------------
package fcn_pkg;

	typedef struct packed {
		logic [31:0] inside_address;
		logic [15:0] inside_port;
		logic [15:0] public_port;
		logic        replied;
		logic [31:0] last_seen;
	} entry_t;

	typedef enum logic [1:0] {
		ACT_OUTBOUND = 2'd0,
		ACT_INBOUND  = 2'd1,
		ACT_TICK     = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_DROP   = 2'd1,
		VERDICT_PASS   = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		REG_PUBLIC_ADDRESS   = 3'd0,
		REG_LOW_PORT         = 3'd1,
		REG_HIGH_PORT        = 3'd2,
		REG_NEW_TIMEOUT      = 3'd3,
		REG_STREAM_TIMEOUT   = 3'd4,
		REG_SESSIONS_PER_SRC = 3'd5
	} reg_index_t;

	localparam logic [31:0] RESET_PUBLIC_ADDRESS = 32'd0;
	localparam logic [15:0] RESET_LOW_PORT       = 16'd1024;
	localparam logic [15:0] RESET_HIGH_PORT      = 16'd65535;
	localparam logic [15:0] RESET_NEW_TIMEOUT    = 16'd60;
	localparam logic [15:0] RESET_STREAM_TIMEOUT = 16'd300;
	localparam logic [15:0] RESET_SESSIONS       = 16'd0;
	localparam logic [31:0] RESET_SECONDS        = 32'd1;
	localparam logic [15:0] CSUM_NONE_SENT       = 16'hffff;

	// One incremental update of a 16-bit word under a one's complement sum.
	function automatic logic [15:0] csum16(input logic [15:0] c, input logic [15:0] o,
			input logic [15:0] n);
		logic [17:0] x;
		logic [16:0] y;
		x = {2'b00, ~c} + {2'b00, ~o} + {2'b00, n};
		y = {1'b0, x[15:0]} + {15'd0, x[17:16]};
		return ~(y[15:0] + {15'd0, y[16]});
	endfunction

endpackage
`default_nettype wire

FILE: rtl/full_cone_udp_nat_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// full_cone_udp_nat_table_unit
// Full-cone UDP NAT engine: mapping lookup and allocation, inbound reply
// handling, tick driven aging and incremental checksum rewrite.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                 Payload
// input     in_valid / in_stall       action, is_udp, addresses, ports, checksums
// result    out_valid / out_stall     verdict, rewritten_address/port, checksums
// config    cfg_we                    cfg_index, cfg_data (no read-back)
//
// A tick holds the input off for one pass over the entry memory, one entry
// per cycle through its single read port, and gives no result. A lookup
// holds the input off for its scan and, for a new mapping, for each round of
// the free port search; packets that bypass the table skip the scan. These
// items then wait until the output register can take their result, and free
// the input in the same cycle that the result shows. Valid bits live in
// flip-flops, so reset needs no clearing pass. A stalled result sits in the
// output register while the next item is already accepted and worked on.
// ----------------------------------------------------------------------------
module full_cone_udp_nat_table_unit
	import fcn_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic        is_udp,
	input  wire logic [31:0] source_address,
	input  wire logic [15:0] source_port,
	input  wire logic [31:0] dest_address,
	input  wire logic [15:0] dest_port,
	input  wire logic [15:0] ip_checksum_in,
	input  wire logic [15:0] udp_checksum_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       verdict,
	output logic [31:0]      rewritten_address,
	output logic [15:0]      rewritten_port,
	output logic [15:0]      ip_checksum_out,
	output logic [15:0]      udp_checksum_out,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_SCAN = 8'b0000_0010,
		ST_PORT = 8'b0000_0100,
		ST_UPD  = 8'b0000_1000,
		ST_CS1  = 8'b0001_0000,
		ST_CS2  = 8'b0010_0000,
		ST_CS3  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	// Configuration registers.
	logic [31:0] public_q;
	logic [15:0] low_q, high_q, new_to_q, stream_to_q, sessions_q;

	// Engine state.
	state_t                  state_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0]             seconds_q;
	logic [15:0]             next_cand_q;

	// Latched item.
	action_t     op_q;
	logic [31:0] sa_q, da_q;
	logic [15:0] sp_q, dp_q, uc_q;

	// Scan pipeline: address issue and the read beat in the cycle after.
	logic [IW-1:0] addr_q;
	logic          issue_done_q;
	logic          rd_v_s1;
	logic [IW-1:0] idx_s1;
	logic          issuing;
	entry_t        rd_s1;

	// Outbound scan bookkeeping and the port search.
	logic [CW-1:0] cnt_q;
	logic          slot_found_q;
	logic [IW-1:0] wr_idx_q;
	logic [15:0]   cand_q;
	logic [16:0]   adv_q;
	logic          changed_q;
	entry_t        ent_q;

	// Checksum rewrite operands.
	logic [31:0] olda_q, newa_q;
	logic [15:0] oldp_q, newp_q, ck_ip_q, ck_udp_q;

	// Finished result waiting for the output register.
	verdict_t    res_verdict_q;
	logic [31:0] res_addr_q;
	logic [15:0] res_port_q, res_ip_q, res_udp_q;

	logic        out_valid_q;
	verdict_t    out_verdict_q;
	logic [31:0] out_addr_q;
	logic [15:0] out_port_q, out_ip_q, out_udp_q;

	// Beat decode.
	logic          beat_v, beat_last, beat_exp, beat_out_hit, beat_in_hit, beat_port_hit;
	logic [31:0]   beat_age, beat_lim;
	logic [CW-1:0] cnt_nx;
	logic          slot_found_nx;
	logic [IW-1:0] slot_nx;
	logic          limit_hit;
	logic [16:0]   span;
	logic [15:0]   cand_wrap, cand_init;
	entry_t        ram_wdata;

	assign issuing = (state_q == ST_SCAN || state_q == ST_PORT) && !issue_done_q;

	fcn_entry_ram #(
		.DEPTH(TABLE_ENTRIES),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (state_q == ST_UPD),
		.waddr(wr_idx_q),
		.wdata(ram_wdata),
		.re   (issuing),
		.raddr(addr_q),
		.rdata(rd_s1)
	);

	assign ram_wdata = ent_q;

	always_comb begin
		beat_v        = valid_q[idx_s1];
		beat_last     = (idx_s1 == LAST_IDX);
		beat_age      = seconds_q - rd_s1.last_seen;
		beat_lim      = {16'd0, rd_s1.replied ? stream_to_q : new_to_q};
		beat_exp      = (beat_age >= beat_lim);
		beat_out_hit  = beat_v && rd_s1.inside_address == sa_q && rd_s1.inside_port == sp_q;
		beat_in_hit   = beat_v && rd_s1.public_port == dp_q;
		beat_port_hit = (beat_v && rd_s1.public_port == cand_q) || cand_q == 16'd0;
		cnt_nx        = cnt_q + CW'(beat_v && rd_s1.inside_address == sa_q);
		slot_found_nx = slot_found_q || !beat_v;
		slot_nx       = slot_found_q ? wr_idx_q : idx_s1;
		limit_hit     = (sessions_q != 16'd0) && (32'(cnt_nx) >= {16'd0, sessions_q});
		span          = {1'b0, high_q} - {1'b0, low_q} + 17'd1;
		cand_wrap     = (cand_q >= high_q) ? low_q : cand_q + 16'd1;
		cand_init     = (next_cand_q < low_q || next_cand_q > high_q) ? low_q : next_cand_q;
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			public_q     <= RESET_PUBLIC_ADDRESS;
			low_q        <= RESET_LOW_PORT;
			high_q       <= RESET_HIGH_PORT;
			new_to_q     <= RESET_NEW_TIMEOUT;
			stream_to_q  <= RESET_STREAM_TIMEOUT;
			sessions_q   <= RESET_SESSIONS;
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			seconds_q    <= RESET_SECONDS;
			next_cand_q  <= RESET_LOW_PORT;
			addr_q       <= '0;
			issue_done_q <= 1'b1;
			rd_v_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PUBLIC_ADDRESS:   public_q    <= cfg_data;
					REG_LOW_PORT:         low_q       <= cfg_data[15:0];
					REG_HIGH_PORT:        high_q      <= cfg_data[15:0];
					REG_NEW_TIMEOUT:      new_to_q    <= cfg_data[15:0];
					REG_STREAM_TIMEOUT:   stream_to_q <= cfg_data[15:0];
					REG_SESSIONS_PER_SRC: sessions_q  <= cfg_data[15:0];
					default: ;
				endcase
			end

			// The read beat follows each issued address in the next cycle.
			rd_v_s1 <= issuing;
			if (issuing) begin
				addr_q <= addr_q + IW'(1);
				if (addr_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end
			end

			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q         <= action_t'(action);
						sa_q         <= source_address;
						sp_q         <= source_port;
						da_q         <= dest_address;
						dp_q         <= dest_port;
						uc_q         <= udp_checksum_in;
						ck_ip_q      <= ip_checksum_in;
						ck_udp_q     <= udp_checksum_in;
						addr_q       <= '0;
						issue_done_q <= 1'b0;
						cnt_q        <= '0;
						slot_found_q <= 1'b0;
						case (action_t'(action))
							ACT_TICK: begin
								seconds_q <= seconds_q + 32'd1;
								state_q   <= ST_SCAN;
							end
							ACT_OUTBOUND: begin
								if (!is_udp) begin
									res_verdict_q <= VERDICT_PASS;
									res_addr_q    <= source_address;
									res_port_q    <= source_port;
									res_ip_q      <= ip_checksum_in;
									res_udp_q     <= udp_checksum_in;
									issue_done_q  <= 1'b1;
									state_q       <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							ACT_INBOUND: begin
								if (!is_udp || dest_address != public_q) begin
									res_verdict_q <= VERDICT_PASS;
									res_addr_q    <= dest_address;
									res_port_q    <= dest_port;
									res_ip_q      <= ip_checksum_in;
									res_udp_q     <= udp_checksum_in;
									issue_done_q  <= 1'b1;
									state_q       <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								issue_done_q <= 1'b1;
							end
						endcase
					end
				end

				// Leaving this state stops the issue by itself; the next
				// transfer restarts it from entry zero.
				ST_SCAN: begin
					if (rd_v_s1) begin
						case (op_q)
							ACT_TICK: begin
								if (beat_v && beat_exp) begin
									valid_q[idx_s1] <= 1'b0;
								end
								if (beat_last) begin
									state_q <= ST_IDLE;
								end
							end
							ACT_OUTBOUND: begin
								if (beat_out_hit) begin
									ent_q    <= {rd_s1.inside_address, rd_s1.inside_port,
										rd_s1.public_port, rd_s1.replied, seconds_q};
									wr_idx_q <= idx_s1;
									olda_q   <= sa_q;
									oldp_q   <= sp_q;
									newa_q   <= public_q;
									newp_q   <= rd_s1.public_port;
									state_q  <= ST_UPD;
								end else begin
									cnt_q        <= cnt_nx;
									slot_found_q <= slot_found_nx;
									wr_idx_q     <= slot_nx;
									if (beat_last) begin
										if (limit_hit || !slot_found_nx || low_q > high_q) begin
											res_verdict_q <= VERDICT_DROP;
											res_addr_q    <= '0;
											res_port_q    <= '0;
											res_ip_q      <= '0;
											res_udp_q     <= '0;
											state_q       <= ST_DONE;
										end else begin
											cand_q       <= cand_init;
											adv_q        <= '0;
											changed_q    <= 1'b0;
											addr_q       <= '0;
											issue_done_q <= 1'b0;
											state_q      <= ST_PORT;
										end
									end
								end
							end
							default: begin
								if (beat_in_hit) begin
									if (beat_exp) begin
										res_verdict_q <= VERDICT_DROP;
										res_addr_q    <= '0;
										res_port_q    <= '0;
										res_ip_q      <= '0;
										res_udp_q     <= '0;
										state_q       <= ST_DONE;
									end else begin
										ent_q    <= {rd_s1.inside_address, rd_s1.inside_port,
											rd_s1.public_port, 1'b1, seconds_q};
										wr_idx_q <= idx_s1;
										olda_q   <= da_q;
										oldp_q   <= dp_q;
										newa_q   <= rd_s1.inside_address;
										newp_q   <= rd_s1.inside_port;
										state_q  <= ST_UPD;
									end
								end else if (beat_last) begin
									res_verdict_q <= VERDICT_PASS;
									res_addr_q    <= da_q;
									res_port_q    <= dp_q;
									res_ip_q      <= ck_ip_q;
									res_udp_q     <= uc_q;
									state_q       <= ST_DONE;
								end
							end
						endcase
					end
				end

				// Each pass walks the table once, stepping the candidate past
				// every port found in use; a pass with no step proves it free.
				ST_PORT: begin
					if (rd_v_s1) begin
						if (beat_port_hit && (adv_q + 17'd1 == span)) begin
							res_verdict_q <= VERDICT_DROP;
							res_addr_q    <= '0;
							res_port_q    <= '0;
							res_ip_q      <= '0;
							res_udp_q     <= '0;
							state_q       <= ST_DONE;
						end else begin
							if (beat_port_hit) begin
								cand_q <= cand_wrap;
								adv_q  <= adv_q + 17'd1;
							end
							if (beat_last) begin
								if (changed_q || beat_port_hit) begin
									changed_q    <= 1'b0;
									addr_q       <= '0;
									issue_done_q <= 1'b0;
								end else begin
									ent_q       <= {sa_q, sp_q, cand_q, 1'b0, seconds_q};
									next_cand_q <= cand_wrap;
									olda_q      <= sa_q;
									oldp_q      <= sp_q;
									newa_q      <= public_q;
									newp_q      <= cand_q;
									state_q     <= ST_UPD;
								end
							end else begin
								changed_q <= changed_q || beat_port_hit;
							end
						end
					end
				end

				ST_UPD: begin
					valid_q[wr_idx_q] <= 1'b1;
					state_q           <= ST_CS1;
				end

				ST_CS1: begin
					ck_ip_q  <= csum16(ck_ip_q, olda_q[31:16], newa_q[31:16]);
					ck_udp_q <= csum16(ck_udp_q, olda_q[31:16], newa_q[31:16]);
					state_q  <= ST_CS2;
				end

				ST_CS2: begin
					ck_ip_q  <= csum16(ck_ip_q, olda_q[15:0], newa_q[15:0]);
					ck_udp_q <= csum16(ck_udp_q, olda_q[15:0], newa_q[15:0]);
					state_q  <= ST_CS3;
				end

				ST_CS3: begin
					res_verdict_q <= VERDICT_ACCEPT;
					res_addr_q    <= newa_q;
					res_port_q    <= newp_q;
					res_ip_q      <= ck_ip_q;
					// A zero checksum means none was sent; a computed zero goes
					// out as all ones.
					if (uc_q == 16'd0) begin
						res_udp_q <= 16'd0;
					end else if (csum16(ck_udp_q, oldp_q, newp_q) == 16'd0) begin
						res_udp_q <= CSUM_NONE_SENT;
					end else begin
						res_udp_q <= csum16(ck_udp_q, oldp_q, newp_q);
					end
					state_q <= ST_DONE;
				end

				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						out_verdict_q <= res_verdict_q;
						out_addr_q    <= res_addr_q;
						out_port_q    <= res_port_q;
						out_ip_q      <= res_ip_q;
						out_udp_q     <= res_udp_q;
						state_q       <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
	end

	assign out_valid         = out_valid_q;
	assign verdict           = out_verdict_q;
	assign rewritten_address = out_addr_q;
	assign rewritten_port    = out_port_q;
	assign ip_checksum_out   = out_ip_q;
	assign udp_checksum_out  = out_udp_q;

endmodule
`default_nettype wire

FILE: rtl/fcn_entry_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcn_entry_ram
// Mapping table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fcn_entry_ram
	import fcn_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
